/* hdl/mmb_pkg.sv */
// ----------------------------------------------------------------------------
// MMB block cipher package
// Shared types, constants and round functions of the MMB cipher pipeline.
// ----------------------------------------------------------------------------
package mmb_pkg;

	typedef logic [3:0][31:0] word4_t;

	localparam int unsigned NUM_ROUNDS = 6;
	localparam int unsigned KEY_WORDS  = 4;
	localparam int unsigned ADDR_W     = 4;

	localparam logic [31:0] DELTA = 32'h2AAA_AAAA;
	localparam logic [31:0] BIAS  = 32'h0000_0DAE;

	localparam logic       MODE_ENC = 1'b0;
	localparam logic       MODE_DEC = 1'b1;

	localparam logic [2:0] LAST_ENC_KEY = 3'd6;
	localparam logic [2:0] LAST_DEC_KEY = 3'd0;

	function automatic logic [31:0] mul_const(input logic mode, input logic [1:0] lane);
		logic [31:0] c;
		c = 32'h0;
		case ({mode, lane})
			{MODE_ENC, 2'd0}: c = 32'h025F_1CDB;
			{MODE_ENC, 2'd1}: c = 32'h04BE_39B6;
			{MODE_ENC, 2'd2}: c = 32'h12F8_E6D8;
			{MODE_ENC, 2'd3}: c = 32'h2F8E_6D81;
			{MODE_DEC, 2'd0}: c = 32'h0DAD_4694;
			{MODE_DEC, 2'd1}: c = 32'h06D6_A34A;
			{MODE_DEC, 2'd2}: c = 32'h81B5_A8D2;
			{MODE_DEC, 2'd3}: c = 32'h281B_5A8D;
			default: c = 32'h0;
		endcase
		return c;
	endfunction

	function automatic logic [31:0] mod_reduce(input logic [63:0] p);
		logic [32:0] s;
		s = {1'b0, p[63:32]} + {1'b0, p[31:0]};
		return s[31:0] + 32'(s[32]);
	endfunction

	function automatic word4_t delta_step(input word4_t w);
		word4_t o;
		o = w;
		if (w[0][0]) begin
			o[0] = w[0] ^ DELTA;
		end
		if (!w[3][0]) begin
			o[3] = w[3] ^ DELTA;
		end
		return o;
	endfunction

	function automatic word4_t theta_step(input word4_t w);
		logic [31:0] a;
		logic [31:0] b;
		word4_t o;
		a = w[0] ^ w[2];
		b = w[1] ^ w[3];
		o[0] = w[0] ^ b;
		o[1] = w[1] ^ a;
		o[2] = w[2] ^ b;
		o[3] = w[3] ^ a;
		return o;
	endfunction

	function automatic word4_t key_add(input word4_t w, input word4_t key, input logic [2:0] r);
		word4_t o;
		logic [1:0] idx;
		for (int j = 0; j < 4; j++) begin
			idx = r[1:0] + 2'(j);
			o[j] = w[j] ^ key[idx];
		end
		o[0] = o[0] ^ (BIAS << r);
		return o;
	endfunction

endpackage

/* hdl/mmb_block_cipher_unit.sv */
// ----------------------------------------------------------------------------
// MMB block cipher unit
// Pipelined 128-bit MMB encrypt/decrypt engine with an APB key port.
// ----------------------------------------------------------------------------
// The unit accepts one 128-bit word per cycle unless out_ready stalls it,
// and passes it through six rounds of two stages each, set by the 32x32
// modular multiplier and its reduction, plus one output register for the
// final key addition. Encrypt and decrypt words may be mixed freely. Keys
// must be written only while the pipeline is empty.
module mmb_block_cipher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [mmb_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [31:0] data_word_0,
	input  logic [31:0] data_word_1,
	input  logic [31:0] data_word_2,
	input  logic [31:0] data_word_3,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_word_0,
	output logic [31:0] out_word_1,
	output logic [31:0] out_word_2,
	output logic [31:0] out_word_3
);
	import mmb_pkg::*;

	word4_t      key_q;
	logic [1:0]  reg_idx;

	logic        rv   [NUM_ROUNDS+1];
	logic        rr   [NUM_ROUNDS+1];
	logic        rm   [NUM_ROUNDS+1];
	word4_t      rw   [NUM_ROUNDS+1];

	logic        out_valid_q;
	word4_t      out_words_q;
	logic        out_stage_ready;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign prdata  = key_q[reg_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (psel && penable && pwrite) begin
			key_q[reg_idx] <= pwdata;
		end
	end

	assign rv[0]    = in_valid;
	assign in_ready = rr[0];
	assign rm[0]    = mode;
	assign rw[0]    = {data_word_3, data_word_2, data_word_1, data_word_0};

	for (genvar k = 0; k < NUM_ROUNDS; k++) begin : g_round
		mmb_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.rnd       (3'(k)),
			.key       (key_q),
			.in_valid  (rv[k]),
			.in_ready  (rr[k]),
			.in_mode   (rm[k]),
			.in_words  (rw[k]),
			.out_valid (rv[k+1]),
			.out_ready (rr[k+1]),
			.out_mode  (rm[k+1]),
			.out_words (rw[k+1])
		);
	end

	assign out_stage_ready  = !out_valid_q || out_ready;
	assign rr[NUM_ROUNDS]   = out_stage_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_stage_ready) begin
			out_valid_q <= rv[NUM_ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_stage_ready && rv[NUM_ROUNDS]) begin
			out_words_q <= key_add(rw[NUM_ROUNDS], key_q,
				(rm[NUM_ROUNDS] == MODE_DEC) ? LAST_DEC_KEY : LAST_ENC_KEY);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_word_0 = out_words_q[0];
	assign out_word_1 = out_words_q[1];
	assign out_word_2 = out_words_q[2];
	assign out_word_3 = out_words_q[3];

`ifndef NO_ASSERTIONS
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid_q && !out_ready))
		else $error("input stalled while the output stage can move");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(rv[NUM_ROUNDS]))
		else $error("output word appeared without a word from the last round");

	a_last_round_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rv[NUM_ROUNDS] && !out_stage_ready) |=> rv[NUM_ROUNDS])
		else $error("last round word lost while the output stage was stalled");
`endif

endmodule

/* hdl/mmb_round.sv */
// ----------------------------------------------------------------------------
// MMB round
// One cipher round in two pipeline stages: key add and modular multiply,
// then reduction; delta/theta follow it, or precede the multiply to decrypt.
// ----------------------------------------------------------------------------
module mmb_round (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [2:0]     rnd,
	input  mmb_pkg::word4_t key,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           in_mode,
	input  mmb_pkg::word4_t in_words,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           out_mode,
	output mmb_pkg::word4_t out_words
);
	import mmb_pkg::*;

	logic              valid_s1;
	logic              mode_s1;
	logic [3:0][63:0]  prod_s1;
	logic              valid_s2;
	logic              mode_s2;
	word4_t            words_s2;
	logic              ready_s1;
	logic              ready_s2;
	logic [2:0]        key_rnd;
	word4_t            ka;
	word4_t            pre;
	word4_t            red;
	word4_t            post;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_comb begin
		key_rnd = (in_mode == MODE_DEC) ? (3'd6 - rnd) : rnd;
		ka = key_add(in_words, key, key_rnd);
		pre = (in_mode == MODE_DEC) ? delta_step(theta_step(ka)) : ka;
		for (int j = 0; j < 4; j++) begin
			red[j] = mod_reduce(prod_s1[j]);
		end
		post = (mode_s1 == MODE_DEC) ? red : theta_step(delta_step(red));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			mode_s1 <= in_mode;
			for (int j = 0; j < 4; j++) begin
				prod_s1[j] <= 64'(pre[j]) * 64'(mul_const(in_mode, 2'(j)));
			end
		end
		if (ready_s2 && valid_s1) begin
			mode_s2  <= mode_s1;
			words_s2 <= post;
		end
	end

	assign out_valid = valid_s2;
	assign out_mode  = mode_s2;
	assign out_words = words_s2;

endmodule
